FILE: hdl/itoa_pkg.sv
// Shared widths, character codes and status types for the signed integer to ASCII block.
package itoa_pkg;

    localparam int MAG_W      = 32;
    localparam int DIGIT_W    = 4;
    localparam int NUM_DIGITS = 10;
    localparam int CNT_W      = 5;
    localparam int IDX_W      = 4;
    localparam int CHAR_W     = 8;

    localparam logic [CNT_W-1:0]  LAST_ITER  = CNT_W'(MAG_W - 1);
    localparam logic [CHAR_W-1:0] CHAR_ZERO  = 8'd48;
    localparam logic [CHAR_W-1:0] CHAR_MINUS = 8'd45;
    localparam logic [CHAR_W-1:0] CHAR_NINE  = 8'd57;

    typedef logic [NUM_DIGITS-1:0][DIGIT_W-1:0] bcd_t;

    typedef struct packed {
        logic busy;
        logic done;
    } dabble_stat_t;

endpackage

FILE: hdl/itoa_dabble.sv
// Iterative binary to BCD converter: one shift-and-add-3 step per cycle.
module itoa_dabble
    import itoa_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             load,
    input  logic [MAG_W-1:0] mag,
    output dabble_stat_t     stat,
    output bcd_t             digits
);

    logic [MAG_W-1:0] shift_reg, shift_next;
    bcd_t             bcd_reg, bcd_next, bcd_adj;
    logic [NUM_DIGITS*DIGIT_W-1:0] adj_flat;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             run_reg, run_next;
    logic             done_reg, done_next;

    // Add 3 to every digit of 5 or more, then shift one magnitude bit in.
    always_comb
    begin
        for (int i = 0; i < NUM_DIGITS; i++)
        begin
            if (bcd_reg[i] >= DIGIT_W'(5))
                bcd_adj[i] = bcd_reg[i] + DIGIT_W'(3);
            else
                bcd_adj[i] = bcd_reg[i];
        end
    end

    assign adj_flat = bcd_adj;

    always_comb
    begin
        shift_next = shift_reg;
        bcd_next   = bcd_reg;
        count_next = count_reg;
        run_next   = run_reg;
        done_next  = 1'b0;
        if (load)
        begin
            shift_next = mag;
            bcd_next   = '0;
            count_next = '0;
            run_next   = 1'b1;
        end
        else if (run_reg)
        begin
            bcd_next   = {adj_flat[NUM_DIGITS*DIGIT_W-2:0], shift_reg[MAG_W-1]};
            shift_next = {shift_reg[MAG_W-2:0], 1'b0};
            count_next = count_reg + CNT_W'(1);
            if (count_reg == LAST_ITER)
            begin
                run_next  = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            run_reg   <= 1'b0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            run_reg   <= run_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        shift_reg <= shift_next;
        bcd_reg   <= bcd_next;
    end

    assign stat.busy = run_reg;
    assign stat.done = done_reg;
    assign digits    = bcd_reg;

endmodule

FILE: hdl/signed_int_to_decimal_ascii.sv
// Top level: signed 32-bit integer to decimal ASCII text, one number per transfer, issued as a run of characters.
//
// Usage:
//   Input channel: drive value and raise start; the transfer happens at a rising
//   edge where start is high and busy is low. busy stays high until the last
//   character of that number has been issued.
//   Output channel: each character appears on char_code for exactly one cycle
//   with valid high; last marks the final character of the run. The receiver
//   cannot stall, so it must take every character in the cycle it appears.
// Text: optional '-' for negative values, then the digits most significant
//   first with no leading zeros; zero gives the single character '0'.
// Sequence: the 32-step shift-and-add-3 converter takes one magnitude bit per
//   cycle, the convert state then picks the leading digit, and the sign and
//   emit states issue the characters in turn (at most 11). busy stays high
//   until the last character, and the next transfer is accepted once busy is
//   low.
// Reset: rst_n clears the sequencer and the output strobe; the block comes out
//   of reset idle with busy low and no character pending.
module signed_int_to_decimal_ascii
    import itoa_pkg::*;
(
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    start,
    input  logic signed [MAG_W-1:0] value,
    output logic                    busy,
    output logic                    valid,
    output logic [CHAR_W-1:0]       char_code,
    output logic                    last
);

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CONVERT,
        ST_SIGN,
        ST_EMIT
    } state_t;

    state_t            state_reg, state_next;
    logic              neg_reg, neg_next;
    logic [IDX_W-1:0]  idx_reg, idx_next;
    logic              valid_reg, valid_next;
    logic [CHAR_W-1:0] char_reg, char_next;
    logic              last_reg, last_next;

    logic              accept;
    logic [MAG_W-1:0]  raw;
    logic [MAG_W-1:0]  mag;
    logic [IDX_W-1:0]  lead_idx;
    dabble_stat_t      stat;
    bcd_t              digits;

    assign accept = start && (state_reg == ST_IDLE);
    assign raw    = value;
    // Form the magnitude in unsigned arithmetic; the minimum value maps onto itself.
    assign mag    = raw[MAG_W-1] ? (MAG_W'(0) - raw) : raw;

    itoa_dabble u_dabble (
        .clk    (clk),
        .rst_n  (rst_n),
        .load   (accept),
        .mag    (mag),
        .stat   (stat),
        .digits (digits)
    );

    // Find the most significant nonzero digit; all zero leaves index 0.
    always_comb
    begin
        lead_idx = '0;
        for (int i = 1; i < NUM_DIGITS; i++)
        begin
            if (digits[i] != '0)
                lead_idx = IDX_W'(i);
        end
    end

    always_comb
    begin
        state_next = state_reg;
        neg_next   = neg_reg;
        idx_next   = idx_reg;
        valid_next = 1'b0;
        char_next  = char_reg;
        last_next  = last_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    neg_next   = raw[MAG_W-1];
                    state_next = ST_CONVERT;
                end
            end
            ST_CONVERT:
            begin
                // Hold until the converter finishes, then pick the first digit.
                if (stat.done)
                begin
                    idx_next   = lead_idx;
                    state_next = neg_reg ? ST_SIGN : ST_EMIT;
                end
            end
            ST_SIGN:
            begin
                valid_next = 1'b1;
                char_next  = CHAR_MINUS;
                last_next  = 1'b0;
                state_next = ST_EMIT;
            end
            ST_EMIT:
            begin
                // Issue one digit a cycle, downward; drop back to idle after units.
                valid_next = 1'b1;
                char_next  = CHAR_ZERO + {{(CHAR_W-DIGIT_W){1'b0}}, digits[idx_reg]};
                last_next  = (idx_reg == '0);
                idx_next   = idx_reg - IDX_W'(1);
                if (idx_reg == '0)
                    state_next = ST_IDLE;
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            valid_reg <= 1'b0;
            neg_reg   <= 1'b0;
            idx_reg   <= '0;
            char_reg  <= '0;
            last_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            valid_reg <= valid_next;
            neg_reg   <= neg_next;
            idx_reg   <= idx_next;
            char_reg  <= char_next;
            last_reg  <= last_next;
        end
    end

    assign busy      = (state_reg != ST_IDLE);
    assign valid     = valid_reg;
    assign char_code = char_reg;
    assign last      = last_reg;

`ifndef SYNTHESIS
    a_char_legal: assert property (@(posedge clk) disable iff (!rst_n)
        valid |-> (char_code == CHAR_MINUS) ||
                  ((char_code >= CHAR_ZERO) && (char_code <= CHAR_NINE)))
        else $error("character outside sign and digit codes");

    a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && (char_code == CHAR_MINUS)) |-> !last)
        else $error("sign issued as final character");

    a_gap_after_last: assert property (@(posedge clk) disable iff (!rst_n)
        (valid && last) |=> !valid)
        else $error("character issued after the final one");

    a_done_in_convert: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> (state_reg == ST_CONVERT))
        else $error("converter finished outside the convert phase");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> (busy && stat.busy))
        else $error("transfer did not start the converter");
`endif

endmodule
